### hdl/tsc_pkg.sv
// ============================================================================
// tsc_pkg
// Shared types and constants of the TCP segment checksum checker.
// ============================================================================
package tsc_pkg;

    localparam int WORD_W                = 16;
    localparam int BYTE_W                = 8;
    localparam int COUNT_W               = 16;
    localparam int NIBBLE_W              = 4;
    localparam int OUT_TDATA_W           = 40;
    localparam int QUEUE_DEPTH_DEF       = 4;
    localparam int MAX_SEGMENT_BYTES_DEF = 65535;

    // segment byte positions of the TCP header fields we look at
    localparam logic [COUNT_W-1:0] OFFSET_BYTE_IDX  = 16'd12;
    localparam logic [COUNT_W-1:0] CSUM_HI_BYTE_IDX = 16'd16;
    localparam logic [COUNT_W-1:0] CSUM_LO_BYTE_IDX = 16'd17;

    typedef enum logic {
        KIND_WORD = 1'b0,
        KIND_BYTE = 1'b1
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [WORD_W-1:0]  data;
        logic               last;
    } t_item;

    typedef struct packed {
        logic [NIBBLE_W-1:0] header_words;
        logic                truncated;
        logic                checksum_ok;
        logic [WORD_W-1:0]   received_checksum;
        logic [WORD_W-1:0]   computed_checksum;
    } t_result;

endpackage

### hdl/tsc_front.sv
// ============================================================================
// tsc_front
// Accepts stream items, classifies them as pseudo-header words or segment
// bytes and holds them in a short queue for the back end.
// ============================================================================
module tsc_front #(
    parameter int QUEUE_DEPTH = tsc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_axis_tvalid,
    output logic                         o_s_axis_tready,
    input  logic [tsc_pkg::WORD_W-1:0]   i_s_axis_tdata,
    input  logic                         i_s_axis_tuser,
    input  logic                         i_s_axis_tlast,
    output logic                         o_item_valid,
    output tsc_pkg::t_item               o_item,
    input  logic                         i_item_pop
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

    tsc_pkg::t_item   r_queue [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count,  n_count;

    tsc_pkg::t_item   in_item;
    logic             push;
    logic             pop;

    // drop the high byte of a segment byte, and last on a pseudo-header word
    always_comb begin
        in_item.kind = tsc_pkg::t_kind'(i_s_axis_tuser);
        in_item.last = 1'b0;
        in_item.data = i_s_axis_tdata;
        case (in_item.kind)
            tsc_pkg::KIND_WORD: begin
                in_item.last = 1'b0;
                in_item.data = i_s_axis_tdata;
            end
            tsc_pkg::KIND_BYTE: begin
                in_item.last = i_s_axis_tlast;
                in_item.data = {{(tsc_pkg::WORD_W - tsc_pkg::BYTE_W){1'b0}},
                                i_s_axis_tdata[tsc_pkg::BYTE_W-1:0]};
            end
            default: begin
                in_item.last = 1'b0;
                in_item.data = i_s_axis_tdata;
            end
        endcase
    end

    assign o_s_axis_tready = (r_count != FULL_CNT);
    assign push            = i_s_axis_tvalid && o_s_axis_tready;
    assign o_item_valid    = (r_count != '0);
    assign pop             = i_item_pop && o_item_valid;
    assign o_item          = r_queue[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_queue[r_wr_ptr] <= in_item;
        end
    end

endmodule

### hdl/tsc_back.sv
// ============================================================================
// tsc_back
// Pops classified items, keeps the running ones-complement sum and the
// header captures, and registers one result per segment.
// ============================================================================
module tsc_back #(
    parameter int MAX_SEGMENT_BYTES = tsc_pkg::MAX_SEGMENT_BYTES_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_item_valid,
    input  tsc_pkg::t_item                     i_item,
    output logic                               o_item_pop,
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    output logic [tsc_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata
);

    localparam int W  = tsc_pkg::WORD_W;
    localparam int BW = tsc_pkg::BYTE_W;
    localparam int CW = tsc_pkg::COUNT_W;
    localparam int NW = tsc_pkg::NIBBLE_W;
    localparam logic [CW-1:0] MAX_COUNT = CW'(MAX_SEGMENT_BYTES);

    logic [W-1:0]    r_sum,    n_sum;
    logic [CW-1:0]   r_bytes,  n_bytes;
    logic [BW-1:0]   r_held,   n_held;
    logic            r_odd,    n_odd;
    logic [W-1:0]    r_rx,     n_rx;
    logic [NW-1:0]   r_nibble, n_nibble;
    logic            r_out_valid;
    tsc_pkg::t_result r_result, n_result;

    logic            pop;
    logic            add_en;
    logic [W-1:0]    add_val;
    logic [W:0]      add_raw;
    logic [W-1:0]    add_fold;
    logic [BW-1:0]   in_byte;
    logic [CW-1:0]   bytes_inc;

    assign pop        = i_item_valid && (!i_item.last || !r_out_valid || i_m_axis_tready);
    assign o_item_pop = pop;
    assign in_byte    = i_item.data[BW-1:0];
    assign bytes_inc  = (r_bytes < MAX_COUNT) ? r_bytes + 1'b1 : r_bytes;

    // at most one end-around-carry add per item
    assign add_raw  = {1'b0, r_sum} + {1'b0, add_val};
    assign add_fold = add_raw[W-1:0] + {{(W-1){1'b0}}, add_raw[W]};

    always_comb begin
        add_en   = 1'b0;
        add_val  = '0;
        n_bytes  = r_bytes;
        n_held   = r_held;
        n_odd    = r_odd;
        n_rx     = r_rx;
        n_nibble = r_nibble;
        case (i_item.kind)
            tsc_pkg::KIND_WORD: begin
                add_en  = 1'b1;
                add_val = i_item.data;
            end
            tsc_pkg::KIND_BYTE: begin
                n_bytes = bytes_inc;
                if (r_bytes == tsc_pkg::OFFSET_BYTE_IDX) begin
                    n_nibble = in_byte[BW-1:BW-NW];
                end
                if (r_bytes == tsc_pkg::CSUM_HI_BYTE_IDX ||
                    r_bytes == tsc_pkg::CSUM_LO_BYTE_IDX) begin
                    if (r_bytes == tsc_pkg::CSUM_HI_BYTE_IDX) begin
                        n_rx = {in_byte, r_rx[BW-1:0]};
                    end else begin
                        n_rx = {r_rx[W-1:BW], in_byte};
                    end
                    // pad a leftover byte on the last item
                    if (i_item.last && r_odd) begin
                        add_en  = 1'b1;
                        add_val = {r_held, {BW{1'b0}}};
                    end
                end else if (r_odd) begin
                    add_en  = 1'b1;
                    add_val = {r_held, in_byte};
                    n_odd   = 1'b0;
                    n_held  = '0;
                end else begin
                    n_held = in_byte;
                    n_odd  = 1'b1;
                    if (i_item.last) begin
                        add_en  = 1'b1;
                        add_val = {in_byte, {BW{1'b0}}};
                    end
                end
            end
            default: begin
                add_en = 1'b0;
            end
        endcase
        n_sum = add_en ? add_fold : r_sum;

        n_result.computed_checksum = ~n_sum;
        n_result.received_checksum = n_rx;
        n_result.checksum_ok       = (n_rx == ~n_sum);
        n_result.truncated         = ({{(CW-NW-2){1'b0}}, n_nibble, 2'b00} > n_bytes);
        n_result.header_words      = n_nibble;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum       <= '0;
            r_bytes     <= '0;
            r_held      <= '0;
            r_odd       <= 1'b0;
            r_rx        <= '0;
            r_nibble    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (pop) begin
                if (i_item.last) begin
                    // clear per-packet state
                    r_sum    <= '0;
                    r_bytes  <= '0;
                    r_held   <= '0;
                    r_odd    <= 1'b0;
                    r_rx     <= '0;
                    r_nibble <= '0;
                end else begin
                    r_sum    <= n_sum;
                    r_bytes  <= n_bytes;
                    r_held   <= n_held;
                    r_odd    <= n_odd;
                    r_rx     <= n_rx;
                    r_nibble <= n_nibble;
                end
            end
            if (pop && i_item.last) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop && i_item.last) begin
            r_result <= n_result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(tsc_pkg::OUT_TDATA_W - $bits(tsc_pkg::t_result)){1'b0}},
                              r_result};

    a_clear_after_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && i_item.last) |=> (r_bytes == '0 && !r_odd && r_sum == '0))
        else $error("packet state not cleared after result");

    a_held_zero_when_even: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_odd |-> (r_held == '0))
        else $error("held byte not cleared while no byte is pending");

    a_no_result_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && i_item.last) |-> (!r_out_valid || i_m_axis_tready))
        else $error("result register overwritten while held");

    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bytes <= MAX_COUNT)
        else $error("byte count above limit");

endmodule

### hdl/tcp_segment_checksum_check_top.sv
// ============================================================================
// tcp_segment_checksum_check_top
// TCP segment checksum checker.
// ============================================================================
// Input stream: tuser = 0 carries a 16-bit pseudo-header word in tdata,
// tuser = 1 carries one segment byte in tdata[7:0]; tlast on a segment byte
// closes the segment. Words and bytes are summed as a ones-complement sum;
// segment bytes 16 and 17 are kept aside as the received checksum.
// Output stream: one item per closed segment with the computed and received
// checksums, a match flag, a truncation flag and the data offset nibble.
// Throughput: one input item per cycle while the queue is not full; the
// back end does at most one end-around carry add per item. A last byte is
// written to the queue at its accepting edge; the result register loads
// when the back end pops it, which waits while an older result is held.
// While a result waits on tready, the back end keeps draining non-final
// items; the front queue (QUEUE_DEPTH items) absorbs the rest before tready
// drops. Reset clears the queue, the sum and all per-segment captures.
// ============================================================================
module tcp_segment_checksum_check_top #(
    parameter int QUEUE_DEPTH       = tsc_pkg::QUEUE_DEPTH_DEF,
    parameter int MAX_SEGMENT_BYTES = tsc_pkg::MAX_SEGMENT_BYTES_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    input  logic [tsc_pkg::WORD_W-1:0]         i_s_axis_tdata,  // [15:0] data
    input  logic                               i_s_axis_tuser,  // [0] operation
    input  logic                               i_s_axis_tlast,  // last
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // [15:0] computed_checksum, [31:16] received_checksum, [32] checksum_ok,
    // [33] truncated, [37:34] header_words, [39:38] zero
    output logic [tsc_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata
);

    logic           item_valid;
    tsc_pkg::t_item item;
    logic           item_pop;

    tsc_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_item_valid    (item_valid),
        .o_item          (item),
        .i_item_pop      (item_pop)
    );

    tsc_back #(
        .MAX_SEGMENT_BYTES (MAX_SEGMENT_BYTES)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_item_valid    (item_valid),
        .i_item          (item),
        .o_item_pop      (item_pop),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

endmodule
